[hw/rtl/bdq_pkg.sv]
// bdq_pkg: shared types, codes and default sizes for the bounded deque block.
// No dependencies; used by bdq_store and bounded_deque_remove_kth.
`default_nettype none

package bdq_pkg;

	// default store depth
	localparam int DEPTH_DEF = 64;

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 12;
	localparam int STAT_W   = 2;
	localparam int CNT_OUT_W = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_SECOND = 3'd4;
	localparam logic [OP_W-1:0] OP_REM_KTH    = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SHIFT,
		ST_WALK,
		ST_OUT
	} bdq_state_t;

endpackage

`default_nettype wire

[hw/rtl/bdq_store.sv]
// bdq_store: entry memory of the deque, one write port, one registered read port.
// Depends on bdq_pkg for the word width.
`default_nettype none

module bdq_store #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [bdq_pkg::VAL_W-1:0] wr_data,
	input  wire logic [AW-1:0]            rd_addr,
	output logic      [bdq_pkg::VAL_W-1:0] rd_data
);

	logic [bdq_pkg::VAL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[hw/rtl/bounded_deque_remove_kth.sv]
// bounded_deque_remove_kth: bounded double-ended queue with k-th removal and order check.
// Steps: decode; for a removal, a shift reading the removed entry and every entry behind it
// (a front pop reads only the removed entry); an order walk when two or more entries remain;
// the result word. Input stalls from accept until the result word is taken, so no new word is
// taken while one is in flight; one memory read port walks the shift and the order check.
// Reset (arst_n low, asynchronous): store empty, front slot 0, sequencer idle.
`default_nettype none

module bounded_deque_remove_kth #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bdq_pkg::OP_W-1:0]      op,
	input  wire logic signed [bdq_pkg::VAL_W-1:0] value,
	input  wire logic [bdq_pkg::POS_W-1:0]     position,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bdq_pkg::STAT_W-1:0]         status,
	output logic signed [bdq_pkg::VAL_W-1:0]   removed_value,
	output logic [bdq_pkg::CNT_OUT_W-1:0]      entry_count,
	output logic                               in_order
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;

	bdq_pkg::bdq_state_t state_q, state_nx;

	logic [bdq_pkg::OP_W-1:0]   op_q;
	logic [bdq_pkg::VAL_W-1:0]  value_q;
	logic [bdq_pkg::POS_W-1:0]  pos_q;

	logic [AW-1:0]  front_q;
	logic [CW-1:0]  occ_q;

	// read engine
	logic [AW-1:0]  rd_i_q;
	logic [AW-1:0]  d_i_q;
	logic [AW-1:0]  last_q;
	logic [AW-1:0]  tgt_q;
	logic           rd_act_q;
	logic           dv_q;
	logic [bdq_pkg::VAL_W-1:0] prev_q;

	// result registers
	logic [bdq_pkg::STAT_W-1:0] status_q;
	logic [bdq_pkg::VAL_W-1:0]  removed_q;
	logic                       in_order_q;

	// decode results
	logic [bdq_pkg::STAT_W-1:0] dec_status;
	logic                       dec_shift;
	logic [AW-1:0]              dec_tgt;
	logic [AW-1:0]              dec_last;
	logic [CW-1:0]              dec_occ;
	logic [AW-1:0]              dec_front;

	logic           eng_done;
	logic [CW-1:0]  walk_occ;
	logic [AW-1:0]  front_inc;
	logic [AW-1:0]  front_dec;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [bdq_pkg::VAL_W-1:0]  wr_data;
	logic [AW-1:0]              rd_addr;
	logic [bdq_pkg::VAL_W-1:0]  rd_data;

	// physical slot of a logical index: one add and one wrap
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
			input logic [AW-1:0] idx);
		logic [AW:0] sum;
		sum = (AW+1)'(front) + (AW+1)'(idx);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	// operation decode
	always_comb begin
		dec_status = bdq_pkg::STAT_OK;
		dec_shift  = 1'b0;
		dec_tgt    = '0;
		dec_last   = AW'(occ_q - CW'(1));
		dec_occ    = occ_q;
		dec_front  = front_q;
		case (op_q)
			bdq_pkg::OP_PUSH_FRONT: begin
				if (occ_q == CW'(DEPTH)) begin
					dec_status = bdq_pkg::STAT_FULL;
				end else begin
					dec_occ   = occ_q + CW'(1);
					dec_front = front_dec;
				end
			end
			bdq_pkg::OP_PUSH_BACK: begin
				if (occ_q == CW'(DEPTH)) begin
					dec_status = bdq_pkg::STAT_FULL;
				end else begin
					dec_occ = occ_q + CW'(1);
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (occ_q == '0) begin
					dec_status = bdq_pkg::STAT_EMPTY;
				end else begin
					dec_shift = 1'b1;
					dec_last  = '0;
				end
			end
			bdq_pkg::OP_POP_BACK: begin
				if (occ_q == '0) begin
					dec_status = bdq_pkg::STAT_EMPTY;
				end else begin
					dec_shift = 1'b1;
					dec_tgt   = AW'(occ_q - CW'(1));
				end
			end
			bdq_pkg::OP_REM_SECOND: begin
				if (occ_q < CW'(2)) begin
					dec_status = bdq_pkg::STAT_EMPTY;
				end else begin
					dec_shift = 1'b1;
					dec_tgt   = AW'(occ_q - CW'(2));
				end
			end
			bdq_pkg::OP_REM_KTH: begin
				if (pos_q == '0 || MW'(pos_q) > MW'(occ_q)) begin
					dec_status = bdq_pkg::STAT_EMPTY;
				end else begin
					dec_shift = 1'b1;
					dec_tgt   = AW'(pos_q - bdq_pkg::POS_W'(1));
				end
			end
			default: begin
				// query and unused code: no change
			end
		endcase
	end

	// engine finished: nothing in flight and no read pending
	assign eng_done = !rd_act_q && !dv_q;

	// count that the order walk runs over
	assign walk_occ = (state_q == bdq_pkg::ST_DECODE) ? dec_occ : occ_q - CW'(1);

	// memory ports: push writes in decode, moves write during the shift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = value_q;
		if (state_q == bdq_pkg::ST_DECODE && dec_status == bdq_pkg::STAT_OK) begin
			if (op_q == bdq_pkg::OP_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
			end else if (op_q == bdq_pkg::OP_PUSH_BACK) begin
				wr_en   = 1'b1;
				wr_addr = slot_of(front_q, AW'(occ_q));
			end
		end else if (state_q == bdq_pkg::ST_SHIFT && dv_q && d_i_q != tgt_q) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(front_q, d_i_q - AW'(1));
			wr_data = rd_data;
		end
	end

	assign rd_addr = slot_of(front_q, rd_i_q);

	bdq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nx = bdq_pkg::ST_DECODE;
				end
			end
			bdq_pkg::ST_DECODE: begin
				state_nx = dec_shift ? bdq_pkg::ST_SHIFT : bdq_pkg::ST_WALK;
			end
			bdq_pkg::ST_SHIFT: begin
				if (eng_done) begin
					state_nx = bdq_pkg::ST_WALK;
				end
			end
			bdq_pkg::ST_WALK: begin
				if (eng_done) begin
					state_nx = bdq_pkg::ST_OUT;
				end
			end
			bdq_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_nx = bdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	// control state: pointers, count, read engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			occ_q    <= '0;
			rd_act_q <= 1'b0;
			dv_q     <= 1'b0;
			rd_i_q   <= '0;
			d_i_q    <= '0;
			last_q   <= '0;
			tgt_q    <= '0;
		end else begin
			case (state_q)
				bdq_pkg::ST_DECODE: begin
					occ_q   <= dec_occ;
					front_q <= dec_front;
					dv_q    <= 1'b0;
					if (dec_shift) begin
						rd_i_q   <= dec_tgt;
						tgt_q    <= dec_tgt;
						last_q   <= dec_last;
						rd_act_q <= 1'b1;
					end else begin
						rd_i_q   <= '0;
						last_q   <= AW'(walk_occ - CW'(1));
						rd_act_q <= (walk_occ >= CW'(2));
					end
				end
				bdq_pkg::ST_SHIFT, bdq_pkg::ST_WALK: begin
					dv_q  <= rd_act_q;
					d_i_q <= rd_i_q;
					if (rd_act_q) begin
						rd_i_q <= rd_i_q + AW'(1);
						if (rd_i_q == last_q) begin
							rd_act_q <= 1'b0;
						end
					end
					// end of shift: drop one entry, then start the order walk
					if (state_q == bdq_pkg::ST_SHIFT && eng_done) begin
						occ_q <= occ_q - CW'(1);
						if (op_q == bdq_pkg::OP_POP_FRONT) begin
							front_q <= front_inc;
						end
						rd_i_q   <= '0;
						last_q   <= AW'(walk_occ - CW'(1));
						rd_act_q <= (walk_occ >= CW'(2));
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			bdq_pkg::ST_IDLE: begin
				op_q    <= op;
				value_q <= value;
				pos_q   <= position;
			end
			bdq_pkg::ST_DECODE: begin
				status_q   <= dec_status;
				removed_q  <= '0;
				in_order_q <= 1'b1;
			end
			bdq_pkg::ST_SHIFT: begin
				if (dv_q && d_i_q == tgt_q) begin
					removed_q <= rd_data;
				end
			end
			bdq_pkg::ST_WALK: begin
				// neighbor compare, signed
				if (dv_q) begin
					prev_q <= rd_data;
					if (d_i_q != '0 && $signed(prev_q) > $signed(rd_data)) begin
						in_order_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall      = (state_q != bdq_pkg::ST_IDLE);
	assign out_valid     = (state_q == bdq_pkg::ST_OUT);
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = bdq_pkg::CNT_OUT_W'(occ_q);
	assign in_order      = in_order_q;

endmodule

`default_nettype wire

[dv/bounded_deque_remove_kth_test.sv]
// Self-checking testbench for bounded_deque_remove_kth: a shadow deque predicts each reply,
// a queue-fed driver offers operation words and a monitor checks every reply word.
// Depends on bdq_pkg and the bounded_deque_remove_kth RTL.
`default_nettype none

module bounded_deque_remove_kth_test;

	localparam int DEPTH = bdq_pkg::DEPTH_DEF;
	localparam int RANDOM_OPS = 1700;
	// opcode 7 has no name in the package; the block treats it as a query
	localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE = 3'd7;

	typedef struct {
		logic [bdq_pkg::OP_W-1:0]         op;
		logic signed [bdq_pkg::VAL_W-1:0] value;
		logic [bdq_pkg::POS_W-1:0]        position;
	} deque_op_t;

	typedef struct {
		logic [bdq_pkg::STAT_W-1:0]       status;
		logic signed [bdq_pkg::VAL_W-1:0] removed;
		logic [bdq_pkg::CNT_OUT_W-1:0]    count;
		logic                             ordered;
	} deque_reply_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	wire logic                            in_stall;
	logic [bdq_pkg::OP_W-1:0]             op = '0;
	logic signed [bdq_pkg::VAL_W-1:0]     value = '0;
	logic [bdq_pkg::POS_W-1:0]            position = '0;
	wire logic                            out_valid;
	logic                                 out_stall = 1'b0;
	wire logic [bdq_pkg::STAT_W-1:0]      status;
	wire logic signed [bdq_pkg::VAL_W-1:0] removed_value;
	wire logic [bdq_pkg::CNT_OUT_W-1:0]   entry_count;
	wire logic                            in_order;

	bounded_deque_remove_kth #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_value(removed_value),
		.entry_count(entry_count),
		.in_order(in_order)
	);

	deque_op_t                        ops_to_send[$];
	deque_reply_t                     replies_due[$];
	logic signed [bdq_pkg::VAL_W-1:0] shadow_deque[$];

	int total_ops = -1;
	int ops_sent = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int gen_fill = 0;
	int full_refusals = 0;
	int empty_replies = 0;
	int peak_fill = 0;
	int long_ordered = 0;
	logic hold_off = 1'b0;
	logic drv_offer;
	deque_op_t drv_word;
	deque_reply_t mon_want;

	// idle and stall rates move through phases as words get accepted
	function automatic int sender_idle_pct();
		case ((ops_sent / 150) % 5)
			1: return 82;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case ((ops_sent / 150) % 5)
			2: return 82;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	// shadow deque: apply one accepted word and queue the reply it must produce
	task automatic predict_deque_reply(input logic [bdq_pkg::OP_W-1:0] code,
			input logic signed [bdq_pkg::VAL_W-1:0] val,
			input logic [bdq_pkg::POS_W-1:0] pos);
		deque_reply_t r;
		int n;
		r.status = bdq_pkg::STAT_OK;
		r.removed = '0;
		n = shadow_deque.size();
		case (code)
			bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
				if (n >= DEPTH)
					r.status = bdq_pkg::STAT_FULL;
				else if (code == bdq_pkg::OP_PUSH_FRONT)
					shadow_deque.push_front(val);
				else
					shadow_deque.push_back(val);
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (n == 0)
					r.status = bdq_pkg::STAT_EMPTY;
				else
					r.removed = shadow_deque.pop_front();
			end
			bdq_pkg::OP_POP_BACK: begin
				if (n == 0)
					r.status = bdq_pkg::STAT_EMPTY;
				else
					r.removed = shadow_deque.pop_back();
			end
			bdq_pkg::OP_REM_SECOND: begin
				if (n < 2) begin
					r.status = bdq_pkg::STAT_EMPTY;
				end else begin
					r.removed = shadow_deque[n-2];
					shadow_deque.delete(n-2);
				end
			end
			bdq_pkg::OP_REM_KTH: begin
				if (pos == 0 || int'(pos) > n) begin
					r.status = bdq_pkg::STAT_EMPTY;
				end else begin
					r.removed = shadow_deque[pos-1];
					shadow_deque.delete(pos-1);
				end
			end
			default: ;
		endcase
		n = shadow_deque.size();
		r.count = bdq_pkg::CNT_OUT_W'(n);
		r.ordered = 1'b1;
		for (int i = 1; i < n; i++)
			if (shadow_deque[i-1] > shadow_deque[i])
				r.ordered = 1'b0;
		if (r.status == bdq_pkg::STAT_FULL)
			full_refusals++;
		if (r.status == bdq_pkg::STAT_EMPTY)
			empty_replies++;
		if (n > peak_fill)
			peak_fill = n;
		if (r.ordered && n >= 8)
			long_ordered++;
		replies_due.push_back(r);
	endtask

	// stimulus side: queue a word and track the fill it will leave behind
	task automatic add_op(input logic [bdq_pkg::OP_W-1:0] code,
			input logic signed [bdq_pkg::VAL_W-1:0] val,
			input logic [bdq_pkg::POS_W-1:0] pos);
		deque_op_t w;
		w.op = code;
		w.value = val;
		w.position = pos;
		ops_to_send.push_back(w);
		case (code)
			bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
			bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: if (gen_fill > 0) gen_fill--;
			bdq_pkg::OP_REM_SECOND: if (gen_fill >= 2) gen_fill--;
			bdq_pkg::OP_REM_KTH: if (pos >= 1 && int'(pos) <= gen_fill) gen_fill--;
			default: ;
		endcase
	endtask

	function automatic logic signed [bdq_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			5, 6, 7: return $urandom_range(0, 6) - 3;
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// mostly in range, some zero or one past the end, some anywhere in 12 bits
	function automatic logic [bdq_pkg::POS_W-1:0] pick_position();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? bdq_pkg::POS_W'(0) :
				bdq_pkg::POS_W'(gen_fill + 1);
			1: return bdq_pkg::POS_W'($urandom);
			default: return bdq_pkg::POS_W'($urandom_range(1, gen_fill > 0 ? gen_fill : 1));
		endcase
	endfunction

	// random position bits for words that ignore the position
	function automatic logic [bdq_pkg::POS_W-1:0] any_position();
		return bdq_pkg::POS_W'($urandom);
	endfunction

	task automatic build_stimulus();
		int mode;
		int len;
		int push_pct;
		int limit;
		logic signed [bdq_pkg::VAL_W-1:0] lo;
		logic signed [bdq_pkg::VAL_W-1:0] hi;
		// directed: empty store, one-entry cases, extremes, bad positions, every op
		add_op(bdq_pkg::OP_POP_FRONT, 0, 0);
		add_op(bdq_pkg::OP_POP_BACK, 0, 0);
		add_op(bdq_pkg::OP_REM_SECOND, 0, 0);
		add_op(bdq_pkg::OP_REM_KTH, 0, 1);
		add_op(bdq_pkg::OP_QUERY, 0, 0);
		add_op(bdq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, 0);
		add_op(bdq_pkg::OP_REM_SECOND, 0, 0);
		add_op(bdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 0);
		add_op(bdq_pkg::OP_PUSH_BACK, 0, 0);
		add_op(bdq_pkg::OP_PUSH_FRONT, -32'sd1, 12'hFFF);
		add_op(OP_SPARE, 32'sh7FFF_FFFF, 12'hFFF);
		add_op(bdq_pkg::OP_REM_KTH, 0, 0);
		add_op(bdq_pkg::OP_REM_KTH, 0, 5);
		add_op(bdq_pkg::OP_REM_KTH, 0, 12'hFFF);
		add_op(bdq_pkg::OP_REM_KTH, 0, 2);
		add_op(bdq_pkg::OP_REM_SECOND, 0, 0);
		add_op(bdq_pkg::OP_PUSH_BACK, 5, 0);
		add_op(bdq_pkg::OP_REM_KTH, 0, 3);
		add_op(bdq_pkg::OP_REM_KTH, 0, 1);
		add_op(bdq_pkg::OP_POP_FRONT, 0, 0);
		add_op(bdq_pkg::OP_PUSH_FRONT, 32'sh5555_5555, 0);
		add_op(bdq_pkg::OP_PUSH_BACK, 32'shAAAA_AAAA, 0);
		add_op(bdq_pkg::OP_POP_BACK, 0, 0);
		add_op(bdq_pkg::OP_POP_FRONT, 0, 0);
		limit = ops_to_send.size() + RANDOM_OPS;
		// random episodes: fill to full, drain to empty, churn, sorted runs
		while (ops_to_send.size() < limit) begin
			mode = $urandom_range(0, 3);
			len = (mode == 0) ? $urandom_range(60, 120) : $urandom_range(20, 90);
			push_pct = (mode == 0) ? 90 : (mode == 1) ? 15 : (mode == 2) ? 50 : 80;
			if (mode == 3) begin
				while (gen_fill > 0)
					add_op(bdq_pkg::OP_POP_BACK, $urandom, any_position());
				hi = $urandom_range(0, 40) - 20;
				lo = hi;
			end
			repeat (len) begin
				case ($urandom_range(0, 99))
					0, 1, 2: add_op(bdq_pkg::OP_QUERY, $urandom, any_position());
					3, 4: add_op(OP_SPARE, $urandom, any_position());
					default: begin
						if ($urandom_range(0, 99) < push_pct) begin
							if (mode == 3 && $urandom_range(0, 1)) begin
								hi = hi + $urandom_range(0, 4);
								add_op(bdq_pkg::OP_PUSH_BACK, hi, any_position());
							end else if (mode == 3) begin
								lo = lo - $urandom_range(0, 4);
								add_op(bdq_pkg::OP_PUSH_FRONT, lo, any_position());
							end else begin
								add_op($urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT :
									bdq_pkg::OP_PUSH_BACK, pick_value(), any_position());
							end
						end else begin
							case ($urandom_range(0, 3))
								0: add_op(bdq_pkg::OP_POP_FRONT, $urandom, any_position());
								1: add_op(bdq_pkg::OP_POP_BACK, $urandom, any_position());
								2: add_op(bdq_pkg::OP_REM_SECOND, $urandom, any_position());
								default: add_op(bdq_pkg::OP_REM_KTH, $urandom, pick_position());
							endcase
						end
					end
				endcase
			end
		end
	endtask

	task automatic report_field(input string name,
			input logic signed [bdq_pkg::VAL_W:0] want,
			input logic signed [bdq_pkg::VAL_W:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		mismatches++;
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// driver: offer the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_offer = in_valid;
			if (in_valid && !in_stall) begin
				predict_deque_reply(op, value, position);
				ops_sent++;
				drv_offer = 1'b0;
			end
			if (!drv_offer && ops_to_send.size() > 0 &&
					$urandom_range(0, 99) >= sender_idle_pct()) begin
				drv_word = ops_to_send.pop_front();
				op <= drv_word.op;
				value <= drv_word.value;
				position <= drv_word.position;
				drv_offer = 1'b1;
			end
			in_valid <= drv_offer;
		end
	end

	// monitor: check each reply word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with nothing expected, got status %0d value %0d",
						$time, status, removed_value);
					$display("%0t: unexpected reply count %0d order %0d",
						$time, entry_count, in_order);
					mismatches++;
				end else begin
					mon_want = replies_due.pop_front();
					if (status !== mon_want.status)
						report_field("status", mon_want.status, status);
					if (removed_value !== mon_want.removed)
						report_field("removed_value", mon_want.removed, removed_value);
					if (entry_count !== mon_want.count)
						report_field("entry_count", mon_want.count, entry_count);
					if (in_order !== mon_want.ordered)
						report_field("in_order", mon_want.ordered, in_order);
				end
				replies_seen++;
			end
			out_stall <= hold_off || ($urandom_range(0, 99) < receiver_stall_pct());
		end
	end

	// long receiver hold-off while the sender keeps offering, to back up the input
	initial begin
		wait (ops_sent >= 620);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		build_stimulus();
		total_ops = ops_to_send.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (ops_sent == total_ops);
		wait (replies_seen >= ops_sent);
		repeat (2 * DEPTH + 20) @(posedge clk);
		$display("Ran %0d deque operations, checked %0d replies, %0d mismatches.",
			ops_sent, replies_seen, mismatches);
		$display("Full refusals %0d, empty or bad-position replies %0d, peak fill %0d,",
			full_refusals, empty_replies, peak_fill);
		$display("ordered with 8+ entries %0d.", long_ordered);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
